### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/scgp_pkg.sv
`timescale 1ns / 1ps

package scgp_pkg;

    localparam int unsigned POS_W = 7;
    localparam logic [POS_W-1:0] FRAME_MAX = 7'd64;
    localparam int unsigned ACC_W = 32;
    localparam int unsigned TERM_W = 9;

    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SLOW  = 8'h59;
    localparam logic [7:0] CH_FAST  = 8'h58;
    localparam logic [7:0] CH_STOP  = 8'h5A;
    localparam logic [7:0] CH_FWD   = 8'h41;
    localparam logic [7:0] CH_BACK  = 8'h43;
    localparam logic [7:0] CH_RIGHT = 8'h42;
    localparam logic [7:0] CH_LEFT  = 8'h44;

    // Motion flag bit positions.
    localparam int unsigned MOT_FWD_BIT   = 0;
    localparam int unsigned MOT_BACK_BIT  = 1;
    localparam int unsigned MOT_LEFT_BIT  = 2;
    localparam int unsigned MOT_RIGHT_BIT = 3;

    typedef enum logic [2:0] {
        MOT_CLEAR,
        MOT_FWD,
        MOT_BACK,
        MOT_RIGHT,
        MOT_LEFT
    } motion_op_t;

    // Classified byte, as passed from the front end to the execute side.
    typedef struct packed {
        motion_op_t                mot;
        logic                      set_fast;
        logic                      set_slow;
        logic                      is_open;
        logic                      is_close;
        logic                      code_ok;
        logic [1:0]                code_sel;
        logic signed [TERM_W-1:0]  term;
    } cmd_t;

endpackage

### rtl/scgp_front.sv
`timescale 1ns / 1ps

module scgp_front (
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_rx_byte,
    input  logic            q_full,
    output logic            q_push,
    output scgp_pkg::cmd_t  q_cmd
);
    import scgp_pkg::*;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_cmd = '0;
        case (s_rx_byte)
            CH_STOP:  q_cmd.mot = MOT_CLEAR;
            CH_FWD:   q_cmd.mot = MOT_FWD;
            CH_BACK:  q_cmd.mot = MOT_BACK;
            CH_RIGHT: q_cmd.mot = MOT_RIGHT;
            CH_LEFT:  q_cmd.mot = MOT_LEFT;
            default:  q_cmd.mot = MOT_CLEAR;
        endcase
        q_cmd.set_fast = (s_rx_byte == CH_FAST);
        q_cmd.set_slow = (s_rx_byte == CH_SLOW);
        q_cmd.is_open  = (s_rx_byte == CH_OPEN);
        q_cmd.is_close = (s_rx_byte == CH_CLOSE);
        // Only '0'..'3' select a gain; '#' and everything else fall outside.
        q_cmd.code_ok  = (s_rx_byte inside {[CH_ZERO:CH_THREE]}) && (s_rx_byte != CH_HASH);
        // '0'..'3' carry the gain index in their low two bits.
        q_cmd.code_sel = s_rx_byte[1:0];
        q_cmd.term     = $signed({1'b0, s_rx_byte}) - $signed({1'b0, CH_ZERO});
    end

endmodule

### rtl/scgp_queue.sv
`timescale 1ns / 1ps

module scgp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  scgp_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output scgp_pkg::cmd_t  head_cmd
);
    import scgp_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/scgp_back.sv
`timescale 1ns / 1ps

module scgp_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_not_empty,
    input  scgp_pkg::cmd_t                    q_cmd,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_move_forward,
    output logic                              m_move_back,
    output logic                              m_turn_left,
    output logic                              m_turn_right,
    output logic                              m_fast_mode,
    output logic                              m_gain_valid,
    output logic [1:0]                        m_gain_select,
    output logic signed [scgp_pkg::ACC_W-1:0] m_gain_hundredths
);
    import scgp_pkg::*;

    localparam int unsigned EXT_W = ACC_W + 4;
    localparam logic signed [EXT_W-1:0] ACC_MAX = EXT_W'(32'sh7FFF_FFFF);
    localparam logic signed [EXT_W-1:0] ACC_MIN = EXT_W'(32'sh8000_0000);

    function automatic logic signed [ACC_W-1:0] sat_acc(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [TERM_W-1:0] term
    );
        logic signed [EXT_W-1:0] ext;
        logic signed [EXT_W-1:0] v;
        ext = EXT_W'(acc);
        // acc * 10 as (acc << 3) + (acc << 1)
        v = (ext <<< 3) + (ext <<< 1) + EXT_W'(term);
        if (v > ACC_MAX) begin
            return ACC_MAX[ACC_W-1:0];
        end else if (v < ACC_MIN) begin
            return ACC_MIN[ACC_W-1:0];
        end else begin
            return v[ACC_W-1:0];
        end
    endfunction

    logic                    valid_reg, valid_next;
    logic [3:0]              motion_reg, motion_next;
    logic                    speed_reg, speed_next;
    logic                    open_reg, open_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    code_ok_reg, code_ok_next;
    logic [1:0]              code_sel_reg, code_sel_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    gvalid_reg, gvalid_next;
    logic [1:0]              gsel_reg, gsel_next;
    logic signed [ACC_W-1:0] gval_reg, gval_next;

    // Take the next item whenever the output slot is free or being emptied.
    assign q_pop = q_not_empty && (!valid_reg || m_ready);

    always_comb begin
        valid_next    = valid_reg;
        motion_next   = motion_reg;
        speed_next    = speed_reg;
        open_next     = open_reg;
        pos_next      = pos_reg;
        code_ok_next  = code_ok_reg;
        code_sel_next = code_sel_reg;
        acc_next      = acc_reg;
        gvalid_next   = gvalid_reg;
        gsel_next     = gsel_reg;
        gval_next     = gval_reg;

        if (m_ready) begin
            valid_next = 1'b0;
        end

        if (q_pop) begin
            valid_next = 1'b1;

            if (q_cmd.set_slow) begin
                speed_next = 1'b0;
            end
            if (q_cmd.set_fast) begin
                speed_next = 1'b1;
            end

            case (q_cmd.mot)
                MOT_CLEAR: motion_next = 4'b0000;
                MOT_FWD:   motion_next = 4'b0001 << MOT_FWD_BIT;
                MOT_BACK:  motion_next = 4'b0001 << MOT_BACK_BIT;
                MOT_RIGHT: begin
                    motion_next = motion_reg & ((4'b0001 << MOT_FWD_BIT) |
                                                (4'b0001 << MOT_BACK_BIT));
                    motion_next[MOT_RIGHT_BIT] = 1'b1;
                end
                MOT_LEFT: begin
                    motion_next = motion_reg & ((4'b0001 << MOT_FWD_BIT) |
                                                (4'b0001 << MOT_BACK_BIT));
                    motion_next[MOT_LEFT_BIT] = 1'b1;
                end
                default:   motion_next = 4'b0000;
            endcase

            gvalid_next = 1'b0;
            gsel_next   = 2'd0;
            gval_next   = '0;

            if (q_cmd.is_close) begin
                // A set code implies an open frame past its code byte.
                if (open_reg && code_ok_reg) begin
                    gvalid_next = 1'b1;
                    gsel_next   = code_sel_reg;
                    gval_next   = acc_reg;
                end
                open_next     = 1'b0;
                pos_next      = '0;
                code_ok_next  = 1'b0;
                code_sel_next = 2'd0;
                acc_next      = '0;
            end else begin
                open_next = open_reg || q_cmd.is_open;
                if (open_next && (pos_reg < FRAME_MAX)) begin
                    if (pos_reg == POS_W'(1)) begin
                        code_ok_next  = q_cmd.code_ok;
                        code_sel_next = q_cmd.code_sel;
                    end else if (pos_reg >= POS_W'(3)) begin
                        acc_next = sat_acc(acc_reg, q_cmd.term);
                    end
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            motion_reg   <= 4'b0000;
            speed_reg    <= 1'b0;
            open_reg     <= 1'b0;
            pos_reg      <= '0;
            code_ok_reg  <= 1'b0;
            code_sel_reg <= 2'd0;
            acc_reg      <= '0;
        end else begin
            valid_reg    <= valid_next;
            motion_reg   <= motion_next;
            speed_reg    <= speed_next;
            open_reg     <= open_next;
            pos_reg      <= pos_next;
            code_ok_reg  <= code_ok_next;
            code_sel_reg <= code_sel_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        gvalid_reg <= gvalid_next;
        gsel_reg   <= gsel_next;
        gval_reg   <= gval_next;
    end

    // Motion and speed state only move on a pop, so they double as outputs.
    assign m_valid           = valid_reg;
    assign m_move_forward    = motion_reg[MOT_FWD_BIT];
    assign m_move_back       = motion_reg[MOT_BACK_BIT];
    assign m_turn_left       = motion_reg[MOT_LEFT_BIT];
    assign m_turn_right      = motion_reg[MOT_RIGHT_BIT];
    assign m_fast_mode       = speed_reg;
    assign m_gain_valid      = gvalid_reg;
    assign m_gain_select     = gsel_reg;
    assign m_gain_hundredths = gval_reg;

endmodule

### rtl/serial_command_and_gain_parser_unit.sv
// Serial command and gain parser: takes one received byte per item and returns one result
// item per byte, at a sustained rate of one item per clock while m_ready is held high. Each
// result carries the four motion flags and the speed mode as they stand after that byte,
// plus a gain update when the byte is a '}' closing a frame whose code byte is '0'..'3';
// the gain is a signed fixed-point value in hundredths, saturated to 32 bits, and the gain
// fields read zero when gain_valid is low. The byte decoder writes a two-entry queue, and
// the execute stage that owns all parser state and the output register pops it. The rate
// is set by the execute stage, whose times-ten accumulate and saturation feed back into
// the accumulator every item. With the result channel stalled the block still takes up
// to two more bytes, as the queue fills, before s_ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module serial_command_and_gain_parser_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_move_forward,
    output logic                              m_move_back,
    output logic                              m_turn_left,
    output logic                              m_turn_right,
    output logic                              m_fast_mode,
    output logic                              m_gain_valid,
    output logic [1:0]                        m_gain_select,
    output logic signed [scgp_pkg::ACC_W-1:0] m_gain_hundredths
);
    import scgp_pkg::*;

    // Front end to queue.
    logic q_full;
    logic q_push;
    cmd_t push_cmd;

    // Queue to execute stage.
    logic q_not_empty;
    logic q_pop;
    cmd_t head_cmd;

    // Decode each byte into a command and push it while the queue has room.
    scgp_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    // Hold decoded items so the decoder keeps accepting, until the queue fills, while the result side stalls.
    scgp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // Apply each command to the motion, speed and frame state and register the result.
    scgp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_not_empty       (q_not_empty),
        .q_cmd             (head_cmd),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_move_forward    (m_move_forward),
        .m_move_back       (m_move_back),
        .m_turn_left       (m_turn_left),
        .m_turn_right      (m_turn_right),
        .m_fast_mode       (m_fast_mode),
        .m_gain_valid      (m_gain_valid),
        .m_gain_select     (m_gain_select),
        .m_gain_hundredths (m_gain_hundredths)
    );

    // Gain fields stay zero unless a gain is reported.
    `ASSERT_IMPLIES(a_gain_zero_when_idle, aclk, aresetn, m_valid && !m_gain_valid,
        (m_gain_select == 2'd0) && (m_gain_hundredths == '0))
    // A gain only comes from a close byte, which stops all motion.
    `ASSERT_IMPLIES(a_gain_stops_motion, aclk, aresetn, m_valid && m_gain_valid,
        !m_move_forward && !m_move_back && !m_turn_left && !m_turn_right)
    // Opposing motion flags never show together.
    `ASSERT_IMPLIES(a_motion_exclusive, aclk, aresetn, m_valid,
        !(m_move_forward && m_move_back) && !(m_turn_left && m_turn_right))

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import scgp_pkg::*;

    // How a stimulus row is checked: against the predictor, or against a typed-in value.
    localparam bit CHK_MODEL = 1'b0;
    localparam bit CHK_FIXED = 1'b1;

    localparam logic signed [31:0] GAIN_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] GAIN_MIN = 32'sh8000_0000;

    // Drive-state snapshot carried by one result item.
    typedef struct packed {
        logic              fwd;
        logic              back;
        logic              left;
        logic              right;
        logic              fast;
        logic              gvalid;
        logic [1:0]        gsel;
        logic signed [31:0] gain;
    } drive_status_t;

    typedef struct packed {
        logic [7:0]    rx;
        bit            chk;
        drive_status_t want;
    } stim_row_t;

    // Directed opening: reset values, every motion command, speed, stray close,
    // short frames, a plain gain frame and a '#' frame.
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{8'h00,        CHK_FIXED, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{8'hFF,        CHK_FIXED, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{CH_FAST,      CHK_FIXED, '{0, 0, 0, 0, 1, 0, 0, 0}},
        '{CH_FWD,       CHK_FIXED, '{1, 0, 0, 0, 1, 0, 0, 0}},
        '{CH_RIGHT,     CHK_FIXED, '{1, 0, 0, 1, 1, 0, 0, 0}},
        '{CH_LEFT,      CHK_FIXED, '{1, 0, 1, 0, 1, 0, 0, 0}},
        '{CH_BACK,      CHK_FIXED, '{0, 1, 0, 0, 1, 0, 0, 0}},
        '{CH_STOP,      CHK_FIXED, '{0, 0, 0, 0, 1, 0, 0, 0}},
        '{CH_SLOW,      CHK_FIXED, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{CH_CLOSE,     CHK_FIXED, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{CH_OPEN,      CHK_MODEL, '0},
        '{CH_CLOSE,     CHK_FIXED, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{CH_OPEN,      CHK_MODEL, '0},
        '{CH_THREE,     CHK_MODEL, '0},
        '{CH_CLOSE,     CHK_FIXED, '{0, 0, 0, 0, 0, 1, 3, 0}},
        '{CH_OPEN,      CHK_MODEL, '0},
        '{CH_ZERO + 8'd2, CHK_MODEL, '0},
        '{8'h3A,        CHK_MODEL, '0},
        '{CH_ZERO + 8'd1, CHK_MODEL, '0},
        '{CH_ZERO + 8'd2, CHK_MODEL, '0},
        '{CH_ZERO + 8'd5, CHK_MODEL, '0},
        '{CH_CLOSE,     CHK_FIXED, '{0, 0, 0, 0, 0, 1, 2, 125}},
        '{CH_OPEN,      CHK_MODEL, '0},
        '{CH_HASH,      CHK_MODEL, '0},
        '{CH_CLOSE,     CHK_FIXED, '{0, 0, 0, 0, 0, 0, 0, 0}}
    };

    localparam logic [7:0] MOTION_CMDS [7] = '{
        CH_FWD, CH_BACK, CH_LEFT, CH_RIGHT, CH_STOP, CH_FAST, CH_SLOW
    };

    localparam int RANDOM_ITEMS = 1600;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_move_forward;
    logic        m_move_back;
    logic        m_turn_left;
    logic        m_turn_right;
    logic        m_fast_mode;
    logic        m_gain_valid;
    logic [1:0]  m_gain_select;
    logic signed [ACC_W-1:0] m_gain_hundredths;

    // Parser state as the predictor sees it.
    bit                 frm_open = 1'b0;
    logic [POS_W-1:0]   frm_pos = '0;
    logic [7:0]         frm_code = '0;
    logic signed [31:0] digit_acc = '0;
    logic [3:0]         motion = '0;
    bit                 fast = 1'b0;

    drive_status_t status_q [$];
    int n_sent = 0;
    int n_got = 0;
    int n_err = 0;

    serial_command_and_gain_parser_unit i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_move_forward    (m_move_forward),
        .m_move_back       (m_move_back),
        .m_turn_left       (m_turn_left),
        .m_turn_right      (m_turn_right),
        .m_fast_mode       (m_fast_mode),
        .m_gain_valid      (m_gain_valid),
        .m_gain_select     (m_gain_select),
        .m_gain_hundredths (m_gain_hundredths)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Advance the parser state by one byte and return the drive status it leaves.
    function automatic drive_status_t parse_byte(input logic [7:0] b);
        drive_status_t r;
        longint        acc_next;
        r = '0;
        if (b == CH_SLOW) fast = 1'b0;
        if (b == CH_FAST) fast = 1'b1;

        case (b)
            CH_FWD: begin
                motion = '0;
                motion[MOT_FWD_BIT] = 1'b1;
            end
            CH_BACK: begin
                motion = '0;
                motion[MOT_BACK_BIT] = 1'b1;
            end
            CH_RIGHT: begin
                motion[MOT_LEFT_BIT] = 1'b0;
                motion[MOT_RIGHT_BIT] = 1'b1;
            end
            CH_LEFT: begin
                motion[MOT_RIGHT_BIT] = 1'b0;
                motion[MOT_LEFT_BIT] = 1'b1;
            end
            default: motion = '0;
        endcase

        if (b == CH_CLOSE) begin
            // Emit only for a frame that got its code byte and the code is a gain index.
            if (frm_open && frm_pos >= 2 && frm_code >= CH_ZERO && frm_code <= CH_THREE) begin
                r.gvalid = 1'b1;
                r.gsel   = 2'(frm_code - CH_ZERO);
                r.gain   = digit_acc;
            end
            frm_open  = 1'b0;
            frm_pos   = '0;
            frm_code  = '0;
            digit_acc = '0;
        end else begin
            if (b == CH_OPEN) frm_open = 1'b1;
            if (frm_open && frm_pos < FRAME_MAX) begin
                if (frm_pos == 1) begin
                    frm_code = b;
                end else if (frm_pos >= 3) begin
                    // Any byte counts as a digit term here, saturate at each step.
                    acc_next = longint'(digit_acc) * 10 + longint'(b) - longint'(CH_ZERO);
                    if (acc_next > longint'(GAIN_MAX)) digit_acc = GAIN_MAX;
                    else if (acc_next < longint'(GAIN_MIN)) digit_acc = GAIN_MIN;
                    else digit_acc = 32'(acc_next);
                end
                frm_pos = frm_pos + 1'b1;
            end
        end

        r.fwd   = motion[MOT_FWD_BIT];
        r.back  = motion[MOT_BACK_BIT];
        r.left  = motion[MOT_LEFT_BIT];
        r.right = motion[MOT_RIGHT_BIT];
        r.fast  = fast;
        return r;
    endfunction

    // Offer one byte after a gap (random, or none in some stretches), hold it until taken, then queue its status.
    task automatic send_byte(input logic [7:0] b, input bit chk = CHK_MODEL,
                             input drive_status_t want = '0);
        int            gap;
        drive_status_t pred;
        gap = (((n_sent / 200) % 4) == 2) ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        pred = parse_byte(b);
        status_q.push_back(chk == CHK_FIXED ? want : pred);
        n_sent++;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endtask

    // Sender side and run control.
    initial begin
        int         pick, r, mode, ndig;
        logic [7:0] code, filler, d;
        bit         drained_once;
        drained_once = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[k]) begin
            send_byte(DIRECTED_ROWS[k].rx, DIRECTED_ROWS[k].chk, DIRECTED_ROWS[k].want);
        end

        while (n_sent < $size(DIRECTED_ROWS) + RANDOM_ITEMS) begin
            // Once, stop offering and let the block run dry.
            if (!drained_once && n_sent >= 800) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                while (status_q.size() != 0) @(posedge aclk);
                drained_once = 1'b1;
            end

            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // Gain frame with random content; some come short, long or unclosed.
                r = $urandom_range(0, 99);
                send_byte(CH_OPEN);
                if (r >= 5) begin
                    if (r < 80) code = CH_ZERO + 8'($urandom_range(0, 3));
                    else if (r < 88) code = CH_HASH;
                    else code = 8'($urandom_range(0, 255));
                    send_byte(code);
                end
                if (r >= 12) begin
                    filler = 8'($urandom_range(0, 255));
                    if (filler == CH_CLOSE) filler = CH_OPEN;
                    send_byte(filler);
                    mode = $urandom_range(0, 9);
                    if (r >= 96) ndig = FRAME_MAX + $urandom_range(0, 8);
                    else if (mode inside {6, 7, 9}) ndig = $urandom_range(6, 14);
                    else ndig = $urandom_range(0, 12);
                    for (int i = 0; i < ndig; i++) begin
                        case (mode)
                            6:       d = CH_ZERO + 8'd9;
                            7:       d = 8'h00;
                            8: begin
                                d = 8'($urandom_range(0, 255));
                                if (d == CH_CLOSE) d = CH_OPEN;
                            end
                            9:       d = 8'hFF;
                            default: d = CH_ZERO + 8'($urandom_range(0, 9));
                        endcase
                        send_byte(d);
                    end
                end
                if (r % 20 != 7) send_byte(CH_CLOSE);
            end else if (pick < 85) begin
                send_byte(MOTION_CMDS[$urandom_range(0, 6)]);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (n_err == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, and stretches with no stalls.
    initial begin
        int            stall;
        bit            held;
        drive_status_t got, want;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && n_got >= 400) begin
                stall = 60;
                held  = 1'b1;
            end else if (((n_got / 200) % 4) == 1) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 6);
            end
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);

            got = {m_move_forward, m_move_back, m_turn_left, m_turn_right, m_fast_mode,
                   m_gain_valid, m_gain_select, m_gain_hundredths};
            if (status_q.size() == 0) begin
                $error("result item with nothing expected");
                n_err++;
            end else begin
                want = status_q.pop_front();
                check_field("m_move_forward", want.fwd, got.fwd);
                check_field("m_move_back", want.back, got.back);
                check_field("m_turn_left", want.left, got.left);
                check_field("m_turn_right", want.right, got.right);
                check_field("m_fast_mode", want.fast, got.fast);
                check_field("m_gain_valid", want.gvalid, got.gvalid);
                check_field("m_gain_select", want.gsel, got.gsel);
                check_field("m_gain_hundredths", want.gain, got.gain);
            end
            n_got++;
        end
    end

    // Bail out if the run hangs.
    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
